// File: rtl/sed_pkg.sv
package sed_pkg;

    // Longest run of decoded bytes one input byte can release
    localparam int unsigned MaxBurst = 6;
    localparam int unsigned BurstCntW = 3;

    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChLowerX    = 8'h78;
    localparam logic [7:0] ChLowerU    = 8'h75;

    // UTF-8 boundaries and lead/continuation marks
    localparam logic [15:0] Utf8Lim1 = 16'h0080;
    localparam logic [15:0] Utf8Lim2 = 16'h0800;
    localparam logic [2:0]  Utf8Lead2 = 3'b110;   // 0xC0 lead mark
    localparam logic [3:0]  Utf8Lead3 = 4'b1110;  // 0xE0 lead mark
    localparam logic [1:0]  Utf8Cont  = 2'b10;    // 0x80 continuation mark
    localparam logic [7:0]  Utf8Mask6 = 8'h3F;

    typedef enum logic [1:0]
    {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX  = 2'd2
    } phase_t;

    // One group of decoded bytes released by a single input word
    typedef struct packed
    {
        logic [BurstCntW-1:0]      count;
        logic [MaxBurst-1:0][7:0]  bytes;
        logic                      last;
    } burst_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/string_escape_decoder.sv
// String escape decoder.
// Input channel: in_valid/in_stall carry one raw byte of a string body per
// word, with in_last on the final byte. Output channel: out_valid/out_stall
// carry one decoded byte per word, with out_last on the final decoded byte.
// The front decodes escapes and packs the bytes each input word releases
// (zero to six) into one queue entry; the back sends them one per cycle while
// the receiver does not stall, so an escape expanding to k bytes (a UTF-8
// sequence or a failed escape replayed as plain bytes) leaves as k output
// words. Decoded bytes are offered from the queue. Throughput: one input
// word per cycle while the queue has room. The queue depth (DEPTH entries)
// sets how far input runs ahead of a stalled receiver. When the receiver
// stalls, the output word holds; once the queue fills, in_stall rises until
// an entry drains.
// Reset clears the decoder to plain text and empties the queue.
module string_escape_decoder
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last
);
    import sed_pkg::*;

    logic       accept;
    logic       push;
    logic       pop;
    burst_t     wr_burst;
    burst_t     head;
    q_status_t  qstat;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !in_stall;

    sed_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .push    (push),
        .burst   (wr_burst)
    );

    sed_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_burst),
        .pop     (pop),
        .rd_data (head),
        .status  (qstat)
    );

    sed_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .status    (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

`ifndef SYNTHESIS
    // The final byte of a string always releases at least one decoded byte
    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |-> push)
        else $error("final input byte produced no output");

    // Never write into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("queue written while full");

    // Queue entries never carry an empty burst
    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty |-> (head.count != '0))
        else $error("empty burst at queue head");
`endif

endmodule

// File: rtl/sed_front.sv
module sed_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                push,
    output sed_pkg::burst_t     burst
);
    import sed_pkg::*;

    phase_t         phase_reg, phase_next;
    logic           uni_reg, uni_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic [15:0]    code_reg, code_next;
    logic [7:0]     held_reg [3];
    logic           held_we;

    logic           hex_ok;
    logic [3:0]     hex_val;
    logic           esc_ok;
    logic [7:0]     esc_val;
    logic [15:0]    cp;
    logic           done_digits;
    logic           do_fresh;
    logic           do_give_up;
    burst_t         bu;

    // Append one byte to a burst
    function automatic burst_t put(burst_t b, logic [7:0] v);
        burst_t r;
        r = b;
        if (r.count < BurstCntW'(MaxBurst))
        begin
            r.bytes[r.count] = v;
            r.count = r.count + 1'b1;
        end
        return r;
    endfunction

    // Classify hex digit
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_val = 4'(in_byte - 8'h30);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            hex_val = 4'(in_byte - 8'h37);
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            hex_val = 4'(in_byte - 8'h57);
        else
            hex_ok = 1'b0;
    end

    // Map single-letter escapes
    always_comb
    begin
        esc_ok  = 1'b1;
        esc_val = 8'h00;
        case (in_byte)
            8'h6E:   esc_val = 8'h0A;
            8'h74:   esc_val = 8'h09;
            8'h72:   esc_val = 8'h0D;
            8'h62:   esc_val = 8'h08;
            8'h66:   esc_val = 8'h0C;
            8'h76:   esc_val = 8'h0B;
            8'h30:   esc_val = 8'h00;
            8'h5C:   esc_val = 8'h5C;
            8'h22:   esc_val = 8'h22;
            8'h27:   esc_val = 8'h27;
            default: esc_ok  = 1'b0;
        endcase
    end

    assign cp = {code_reg[11:0], hex_val};
    assign done_digits = uni_reg ? (cnt_reg == 2'd3) : (cnt_reg != 2'd0);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        uni_next   = uni_reg;
        cnt_next   = cnt_reg;
        code_next  = code_reg;
        held_we    = 1'b0;
        do_fresh   = 1'b0;
        do_give_up = 1'b0;
        case (phase_reg)
            PH_ESC:
            begin
                if (esc_ok)
                    phase_next = PH_TEXT;
                else if ((in_byte == ChLowerX || in_byte == ChLowerU) && !in_last)
                begin
                    phase_next = PH_HEX;
                    uni_next   = (in_byte == ChLowerU);
                    cnt_next   = 2'd0;
                    code_next  = 16'd0;
                end
                else
                    do_give_up = 1'b1;
            end
            PH_HEX:
            begin
                if (!hex_ok || (!done_digits && in_last))
                    do_give_up = 1'b1;
                else if (done_digits)
                begin
                    phase_next = PH_TEXT;
                    cnt_next   = 2'd0;
                    code_next  = 16'd0;
                end
                else
                begin
                    held_we   = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    code_next = cp;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase
        if (do_give_up)
        begin
            cnt_next  = 2'd0;
            code_next = 16'd0;
            do_fresh  = 1'b1;
        end
        if (do_fresh)
            phase_next = (in_byte == ChBackslash && !in_last) ? PH_ESC : PH_TEXT;
        if (in_last)
        begin
            phase_next = PH_TEXT;
            cnt_next   = 2'd0;
            code_next  = 16'd0;
        end
    end

    // Build the burst of decoded bytes
    always_comb
    begin
        bu = '0;
        if (phase_reg == PH_ESC && esc_ok)
            bu = put(bu, esc_val);
        if (phase_reg == PH_HEX && hex_ok && done_digits)
        begin
            if (!uni_reg || cp < Utf8Lim1)
                bu = put(bu, cp[7:0]);
            else if (cp < Utf8Lim2)
            begin
                bu = put(bu, {Utf8Lead2, cp[10:6]});
                bu = put(bu, {Utf8Cont, 6'(cp[7:0] & Utf8Mask6)});
            end
            else
            begin
                bu = put(bu, {Utf8Lead3, cp[15:12]});
                bu = put(bu, {Utf8Cont, cp[11:6]});
                bu = put(bu, {Utf8Cont, 6'(cp[7:0] & Utf8Mask6)});
            end
        end
        if (do_give_up)
        begin
            bu = put(bu, ChBackslash);
            if (phase_reg == PH_HEX)
            begin
                bu = put(bu, uni_reg ? ChLowerU : ChLowerX);
                for (int k = 0; k < 3; k++)
                begin
                    if (2'(k) < cnt_reg)
                        bu = put(bu, held_reg[k]);
                end
            end
        end
        if (do_fresh && !(in_byte == ChBackslash && !in_last))
            bu = put(bu, in_byte);
        bu.last = in_last;
    end

    assign burst = bu;
    assign push  = accept && (bu.count != '0);

    // Advance decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            uni_reg   <= 1'b0;
            cnt_reg   <= 2'd0;
            code_reg  <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            uni_reg   <= uni_next;
            cnt_reg   <= cnt_next;
            code_reg  <= code_next;
        end
    end

    // Hold raw digits
    always_ff @(posedge clk)
    begin
        if (accept && held_we)
            held_reg[cnt_reg] <= in_byte;
    end

endmodule

// File: rtl/sed_queue.sv
module sed_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sed_pkg::burst_t     wr_data,
    input  logic                pop,
    output sed_pkg::burst_t     rd_data,
    output sed_pkg::q_status_t  status
);
    import sed_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    burst_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign status.full  = (fill_reg == CW'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: rtl/sed_back.sv
module sed_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  sed_pkg::burst_t     head,
    input  sed_pkg::q_status_t  status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                out_last
);
    import sed_pkg::*;

    logic [BurstCntW-1:0] idx_reg, idx_next;
    logic                 at_end;
    logic                 take;

    assign at_end    = (idx_reg == head.count - 1'b1);
    assign out_valid = !status.empty;
    assign out_byte  = head.bytes[idx_reg];
    assign out_last  = head.last && at_end;
    assign take      = out_valid && !out_stall;
    assign pop       = take && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = at_end ? '0 : idx_reg + 1'b1;
    end

    // Step through the head burst one word at a time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import sed_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int RandomWords = 330;
    localparam int DrainCycles = 20;

    // Simple escape letters and the bytes they stand for, same index
    localparam logic [9:0][7:0] EscLetter =
        {"'", "\"", "\\", "0", "v", "f", "b", "r", "t", "n"};
    localparam logic [9:0][7:0] EscValue =
        {8'h27, 8'h22, 8'h5C, 8'h00, 8'h0B, 8'h0C, 8'h08, 8'h0D, 8'h09, 8'h0A};

    typedef struct packed
    {
        logic [7:0] b;
        logic       l;
    } out_word_t;

    // One directed row: n < 0 means the predictor supplies the bytes
    typedef struct
    {
        logic [7:0]  b;
        logic        l;
        int          n;
        logic [23:0] v;
    } script_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       out_last;

    // Predictor state
    phase_t      dec_phase;
    logic        dec_unicode;
    logic [7:0]  dec_digits [3];
    int unsigned dec_count;
    logic [15:0] dec_code;
    logic [7:0]  burst [$];

    out_word_t   decoded_due [$];
    script_row_t script [$];
    logic [7:0]  raw_text [$];

    logic steady = 1'b0;
    int   cycles = 0;
    int   errors = 0;
    int   words_sent = 0;
    int   words_checked = 0;
    int   strings_sent = 0;

    string_escape_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("MISMATCH %s: expected %0h got %0h (cycle %0d)", what, exp_v, got_v, cycles);
        errors++;
    endtask

    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 10) return "0" + v;
        return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
    endfunction

    // Handle a byte as plain text; a backslash opens an escape unless it ends the string
    function automatic void replay_plain(input logic [7:0] b, input logic l);
        dec_phase = PH_TEXT;
        if (b == ChBackslash && !l)
            dec_phase = PH_ESC;
        else
            burst.push_back(b);
    endfunction

    // Drop a pending escape: release what it held, then redo the current byte
    function automatic void abandon(input logic [7:0] b, input logic l, input logic had_letter);
        burst.push_back(ChBackslash);
        if (had_letter)
        begin
            burst.push_back(dec_unicode ? ChLowerU : ChLowerX);
            for (int k = 0; k < dec_count; k++)
                burst.push_back(dec_digits[k]);
        end
        dec_count = 0;
        dec_code = 0;
        replay_plain(b, l);
    endfunction

    // Advance the predictor by one input word; released bytes land in burst
    function automatic void decode_word(input logic [7:0] b, input logic l);
        int h;
        int s;
        h = digit_value(b);
        s = -1;
        for (int k = 0; k < 10; k++)
            if (EscLetter[k] == b)
                s = k;
        burst.delete();
        case (dec_phase)
            PH_ESC:
            begin
                if (s >= 0)
                begin
                    burst.push_back(EscValue[s]);
                    dec_phase = PH_TEXT;
                end
                else if ((b == ChLowerX || b == ChLowerU) && !l)
                begin
                    dec_phase = PH_HEX;
                    dec_unicode = (b == ChLowerU);
                    dec_count = 0;
                    dec_code = 0;
                end
                else
                    abandon(b, l, 1'b0);
            end
            PH_HEX:
            begin
                if (h < 0)
                    abandon(b, l, 1'b1);
                else if (dec_count + 1 >= (dec_unicode ? 4 : 2))
                begin
                    dec_code = {dec_code[11:0], h[3:0]};
                    // hex byte as is, code point as one to three UTF-8 bytes
                    if (!dec_unicode || dec_code < Utf8Lim1)
                        burst.push_back(dec_code[7:0]);
                    else if (dec_code < Utf8Lim2)
                    begin
                        burst.push_back({Utf8Lead2, dec_code[10:6]});
                        burst.push_back({Utf8Cont, dec_code[5:0]});
                    end
                    else
                    begin
                        burst.push_back({Utf8Lead3, dec_code[15:12]});
                        burst.push_back({Utf8Cont, dec_code[11:6]});
                        burst.push_back({Utf8Cont, dec_code[5:0]});
                    end
                    dec_phase = PH_TEXT;
                    dec_count = 0;
                    dec_code = 0;
                end
                else if (l)
                    abandon(b, l, 1'b1);
                else
                begin
                    dec_digits[dec_count] = b;
                    dec_count++;
                    dec_code = {dec_code[11:0], h[3:0]};
                end
            end
            default:
                replay_plain(b, l);
        endcase
        if (l)
        begin
            dec_phase = PH_TEXT;
            dec_count = 0;
            dec_code = 0;
        end
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic l, input int n,
                                    input logic [23:0] v);
        script.push_back(script_row_t'{b, l, n, v});
    endfunction

    // Queue an escape with the top digits of v; fewer digits than needed leaves it broken
    function automatic void push_escape(input logic u, input logic [15:0] v, input int digits);
        int width;
        width = u ? 4 : 2;
        raw_text.push_back(ChBackslash);
        raw_text.push_back(u ? ChLowerU : ChLowerX);
        for (int k = 0; k < digits; k++)
            raw_text.push_back(hex_char(v[4 * (width - 1 - k) +: 4]));
    endfunction

    // Offer one word, wait for it to be taken, then record the bytes it releases
    task automatic send_word(input logic [7:0] b, input logic l, input int typed_n,
                             input logic [23:0] typed);
        logic took;
        while (!steady && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= l;
        do
        begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end
        while (!took);
        decode_word(b, l);
        if (typed_n >= 0)
        begin
            burst.delete();
            for (int k = 0; k < typed_n; k++)
                burst.push_back(typed[23 - 8 * k -: 8]);
        end
        foreach (burst[k])
            decoded_due.push_back(out_word_t'{burst[k], l && (k == burst.size() - 1)});
        words_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_due.size() != 0)
            @(posedge clk);
    endtask

    // Build one string of random tokens, mostly well-formed escapes
    task automatic send_string();
        int r;
        int n_tok;
        logic [15:0] v;
        raw_text.delete();
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                raw_text.push_back(8'($urandom_range(255)));
            else if (r < 55)
            begin
                raw_text.push_back(ChBackslash);
                raw_text.push_back(EscLetter[$urandom_range(9)]);
            end
            else if (r < 70)
                push_escape(1'b0, 16'($urandom_range(255)), 2);
            else if (r < 88)
            begin
                case ($urandom_range(2))
                    0: v = 16'($urandom_range(16'h007F));
                    1: v = 16'($urandom_range(16'h07FF, 16'h0080));
                    default: v = 16'($urandom_range(16'hFFFF, 16'h0800));
                endcase
                push_escape(1'b1, v, 4);
            end
            else if (r < 94)
            begin
                raw_text.push_back(ChBackslash);
                raw_text.push_back(8'($urandom_range(255)));
            end
            else if ($urandom_range(1))
                push_escape(1'b1, 16'($urandom_range(16'hFFFF)), int'($urandom_range(3)));
            else
                push_escape(1'b0, 16'($urandom_range(255)), int'($urandom_range(1)));
        end
        foreach (raw_text[k])
            send_word(raw_text[k], k == raw_text.size() - 1, -1, 24'h0);
        strings_sent++;
    endtask

    // Receiver stalls now and then, except in the steady stretch
    initial out_stall = 1'b0;
    always @(posedge clk)
        out_stall <= !steady && ($urandom_range(99) < 7);

    // Check each decoded word as it is taken
    always @(negedge clk)
    begin : check_output
        out_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_due.size() == 0)
                report_mismatch("decoded word with none due", 0, out_byte);
            else
            begin
                w = decoded_due.pop_front();
                if (out_byte !== w.b)
                    report_mismatch("out_byte", w.b, out_byte);
                if (out_last !== w.l)
                    report_mismatch("out_last", w.l, out_last);
                words_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycles, decoded_due.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        int directed;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        in_last = 1'b0;
        dec_phase = PH_TEXT;
        dec_unicode = 1'b0;
        dec_count = 0;
        dec_code = 16'h0;

        // Byte extremes, simple escapes, hex and code point escapes
        add_row(8'h00, 1'b0, 1, 24'h000000);
        add_row(8'hFF, 1'b0, 1, 24'hFF0000);
        add_row("\\",  1'b0, 0, 24'h0);
        add_row("n",   1'b0, 1, 24'h0A0000);
        add_row("\\",  1'b0, 0, 24'h0);
        add_row("\"",  1'b0, 1, 24'h220000);
        add_row("\\",  1'b0, 0, 24'h0);
        add_row("x",   1'b0, 0, 24'h0);
        add_row("F",   1'b0, 0, 24'h0);
        add_row("f",   1'b0, 1, 24'hFF0000);
        add_row("\\",  1'b0, 0, 24'h0);
        add_row("u",   1'b0, 0, 24'h0);
        add_row("F",   1'b0, 0, 24'h0);
        add_row("F",   1'b0, 0, 24'h0);
        add_row("F",   1'b0, 0, 24'h0);
        add_row("F",   1'b0, 3, 24'hEFBFBF);
        // unknown escape letter
        add_row("\\",  1'b0, 0, 24'h0);
        add_row("q",   1'b0, -1, 24'h0);
        // non-hex byte while collecting digits
        add_row("\\",  1'b0, 0, 24'h0);
        add_row("u",   1'b0, 0, 24'h0);
        add_row("0",   1'b0, 0, 24'h0);
        add_row("7",   1'b0, 0, 24'h0);
        add_row("z",   1'b0, -1, 24'h0);
        // backslash on the last byte
        add_row("\\",  1'b1, 1, 24'h5C0000);
        // string ends inside a hex escape
        add_row("\\",  1'b0, 0, 24'h0);
        add_row("x",   1'b0, 0, 24'h0);
        add_row("A",   1'b1, -1, 24'h0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_word(script[i].b, script[i].l, script[i].n, script[i].v);
        directed = words_sent;
        wait_drained();

        // Random strings with some noise; hold the stream back once mid-run
        while (words_sent - directed < RandomWords)
        begin
            steady <= (words_sent - directed >= 120) && (words_sent - directed < 220);
            if (strings_sent == 20)
                wait_drained();
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 6))
                    send_word(8'($urandom_range(255)), $urandom_range(5) == 0, -1, 24'h0);
            end
            send_string();
        end
        steady <= 1'b0;

        wait_drained();
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d input words (%0d directed) over %0d random strings",
                 words_sent, directed, strings_sent);
        $display("checked %0d decoded words, %0d mismatches", words_checked, errors);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/sed_pkg.sv
rtl/sed_front.sv
rtl/sed_queue.sv
rtl/sed_back.sv
rtl/string_escape_decoder.sv
tb/sv/tb_top.sv
